/* hdl/mob_pkg.sv */
// Shared types, request codes and constants for the memory ordering buffer.
`timescale 1ns / 1ps
`default_nettype none

package mob_pkg;

    localparam int ADDR_W  = 64;
    localparam int IDX_W   = 5;
    localparam int SIZE_W  = 3;
    localparam int TYPE_W  = 3;
    localparam int WIN_W   = 6;

    localparam logic [SIZE_W-1:0] SIZE_MAX   = 3'd4;
    localparam logic [WIN_W-1:0]  WINDOW_RST = 6'd8;

    typedef enum logic [TYPE_W-1:0] {
        REQ_ALLOC = 3'd0,
        REQ_LOAD  = 3'd1,
        REQ_STORE = 3'd2,
        REQ_CLEAR = 3'd3,
        REQ_QUERY = 3'd4
    } t_req_type;

    // Controller -> datapath
    typedef struct packed {
        logic capture;   // latch the request on its transfer
        logic exec;      // apply the request to the entry flags
        logic rd;        // read walk entry address from memory
        logic cmp;       // compare walk entry, cancel on match, advance
        logic load_out;  // move result into the output register
    } t_mob_cmd;

    // Datapath -> controller
    typedef struct packed {
        logic walk_start;  // accepted store with entries to scan
        logic walk_last;   // next walk entry is the allocation pointer
        logic out_busy;    // output register holds an untaken result
    } t_mob_sts;

    // Low address bits ignored for a given access size code
    function automatic logic [3:0] size_mask(input logic [SIZE_W-1:0] sz);
        logic [3:0] m;
        case (sz)
            3'd0:    m = 4'h0;
            3'd1:    m = 4'h1;
            3'd2:    m = 4'h3;
            3'd3:    m = 4'h7;
            3'd4:    m = 4'hF;
            default: m = 4'h0;
        endcase
        return m;
    endfunction

endpackage

`default_nettype wire

/* hdl/mob_req_if.sv */
// Request channel: valid/ready handshake with the request fields.
`timescale 1ns / 1ps
`default_nettype none

interface mob_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  req_type;
    logic [4:0]  entry_index;
    logic        alloc_is_load;
    logic        alloc_is_store;
    logic [63:0] access_address;
    logic [2:0]  access_size;

    modport source (
        output valid, req_type, entry_index, alloc_is_load, alloc_is_store,
               access_address, access_size,
        input  ready
    );
    modport sink (
        input  valid, req_type, entry_index, alloc_is_load, alloc_is_store,
               access_address, access_size,
        output ready
    );
endinterface

`default_nettype wire

/* hdl/mob_rsp_if.sv */
// Response channel: valid/ready handshake with the result fields.
`timescale 1ns / 1ps
`default_nettype none

interface mob_rsp_if;
    logic       valid;
    logic       ready;
    logic       alloc_ok;
    logic [4:0] alloc_index;
    logic       entry_valid;
    logic       entry_cancelled;
    logic       buffer_empty;
    logic       near_full;
    logic       request_error;

    modport source (
        output valid, alloc_ok, alloc_index, entry_valid, entry_cancelled,
               buffer_empty, near_full, request_error,
        input  ready
    );
    modport sink (
        input  valid, alloc_ok, alloc_index, entry_valid, entry_cancelled,
               buffer_empty, near_full, request_error,
        output ready
    );
endinterface

`default_nettype wire

/* hdl/mob_ctrl.sv */
// Sequencing state machine for the memory ordering buffer.
`timescale 1ns / 1ps
`default_nettype none

module mob_ctrl
    import mob_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_req_valid,
    output logic          o_req_ready,
    input  wire t_mob_sts i_sts,
    output t_mob_cmd      o_cmd
);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_EXEC = 5'b00010,
        ST_READ = 5'b00100,
        ST_CMP  = 5'b01000,
        ST_DONE = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_req_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = ST_EXEC;
                end
            end
            ST_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = i_sts.walk_start ? ST_READ : ST_DONE;
            end
            ST_READ: begin
                o_cmd.rd = 1'b1;
                n_state  = ST_CMP;
            end
            ST_CMP: begin
                o_cmd.cmp = 1'b1;
                n_state   = i_sts.walk_last ? ST_DONE : ST_READ;
            end
            ST_DONE: begin
                if (!i_sts.out_busy) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_req_ready = (r_state == ST_IDLE);

    // A transfer always leads into execution of that request
    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req_valid && o_req_ready) |=> (r_state == ST_EXEC))
        else $error("accepted request did not enter execution");

    // The result register is never overwritten while it still holds a result
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_out |-> !i_sts.out_busy)
        else $error("result loaded over an untaken result");

endmodule

`default_nettype wire

/* hdl/mob_dp.sv */
// Entry flags, address memory, store-walk compare and result registers.
`timescale 1ns / 1ps
`default_nettype none

module mob_dp
    import mob_pkg::*;
#(
    parameter int DEPTH = 32
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_mob_cmd          i_cmd,
    output t_mob_sts               o_sts,
    input  wire logic              i_cfg_we,
    input  wire logic [WIN_W-1:0]  i_cfg_wdata,
    input  wire logic [TYPE_W-1:0] i_req_type,
    input  wire logic [IDX_W-1:0]  i_entry_index,
    input  wire logic              i_alloc_is_load,
    input  wire logic              i_alloc_is_store,
    input  wire logic [ADDR_W-1:0] i_access_address,
    input  wire logic [SIZE_W-1:0] i_access_size,
    input  wire logic              i_rsp_ready,
    output logic                   o_rsp_valid,
    output logic                   o_alloc_ok,
    output logic [IDX_W-1:0]       o_alloc_index,
    output logic                   o_entry_valid,
    output logic                   o_entry_cancelled,
    output logic                   o_buffer_empty,
    output logic                   o_near_full,
    output logic                   o_request_error
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int DW = AW + 1;
    localparam int CW = (DW > WIN_W) ? DW : WIN_W;

    // Entry flags
    logic [DEPTH-1:0] r_valid, r_cancel, r_load, r_store, r_known;
    logic [AW-1:0]    r_ptr;
    logic [WIN_W-1:0] r_window;

    // Address/size memory, read one entry per walk step
    logic [ADDR_W-1:0] r_mem_addr [DEPTH];
    logic [SIZE_W-1:0] r_mem_size [DEPTH];
    logic [ADDR_W-1:0] r_rd_addr;
    logic [SIZE_W-1:0] r_rd_size;

    // Captured request
    logic [TYPE_W-1:0] r_req_type;
    logic [IDX_W-1:0]  r_req_idx;
    logic              r_req_ld, r_req_st;
    logic [ADDR_W-1:0] r_req_addr;
    logic [SIZE_W-1:0] r_req_size;

    logic [AW-1:0] r_walk_k;
    logic [AW-1:0] n_walk_k;
    logic [AW-1:0] ptr_inc;

    // Held per-request result
    logic             r_res_ok, r_res_qv, r_res_qc, r_res_err;
    logic [IDX_W-1:0] r_res_aidx;
    logic             r_out_vld;

    logic          idx_ok;
    logic [AW-1:0] ia;
    logic          ld_err, st_err;
    logic          e_ok, e_qv, e_qc, e_err;
    logic          hit;
    logic [DEPTH-1:0] win_hit;
    logic [DW-1:0]    ring_off;

    assign idx_ok  = int'(r_req_idx) < DEPTH;
    assign ia      = AW'(r_req_idx);
    assign ptr_inc = (r_ptr == AW'(DEPTH - 1)) ? '0 : r_ptr + 1'b1;
    assign n_walk_k = (r_walk_k == AW'(DEPTH - 1)) ? '0 : r_walk_k + 1'b1;

    assign ld_err = !idx_ok || (r_req_size > SIZE_MAX) || !r_valid[ia] ||
                    !r_load[ia] || r_known[ia];
    assign st_err = !idx_ok || (r_req_size > SIZE_MAX) || !r_valid[ia] ||
                    r_cancel[ia] || !r_store[ia] || r_known[ia];

    always_comb begin
        e_ok  = 1'b0;
        e_qv  = 1'b0;
        e_qc  = 1'b0;
        e_err = 1'b0;
        case (r_req_type)
            REQ_ALLOC: e_ok  = !r_valid[r_ptr];
            REQ_LOAD:  e_err = ld_err;
            REQ_STORE: e_err = st_err;
            REQ_CLEAR: e_err = !idx_ok;
            REQ_QUERY: begin
                e_err = !idx_ok;
                e_qv  = idx_ok && r_valid[ia];
                e_qc  = idx_ok && r_valid[ia] && r_cancel[ia];
            end
            default:   e_err = 1'b1;
        endcase
    end

    // Walk compare: load entry, address known, same line after both masks
    assign hit = r_valid[r_walk_k] && !r_cancel[r_walk_k] && !r_store[r_walk_k] &&
                 r_known[r_walk_k] &&
                 (r_rd_addr[ADDR_W-1:4] == r_req_addr[ADDR_W-1:4]) &&
                 ((r_rd_addr[3:0] & ~size_mask(r_rd_size)) ==
                  (r_req_addr[3:0] & ~size_mask(r_req_size)));

    assign o_sts.walk_start = (r_req_type == REQ_STORE) && !st_err && (ia != r_ptr);
    assign o_sts.walk_last  = (n_walk_k == r_ptr);
    assign o_sts.out_busy   = r_out_vld && !i_rsp_ready;

    // Ring distance of each entry from the allocation pointer vs. the window
    always_comb begin
        ring_off = '0;
        for (int k = 0; k < DEPTH; k++) begin
            ring_off = DW'(k) - DW'(r_ptr) +
                       ((DW'(k) < DW'(r_ptr)) ? DW'(DEPTH) : '0);
            win_hit[k] = CW'(ring_off) < CW'(r_window);
        end
    end

    // Control flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= '0;
            r_cancel  <= '0;
            r_load    <= '0;
            r_store   <= '0;
            r_known   <= '0;
            r_ptr     <= '0;
            r_window  <= WINDOW_RST;
            r_out_vld <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_window <= i_cfg_wdata;
            end
            if (i_cmd.exec) begin
                case (r_req_type)
                    REQ_ALLOC: begin
                        if (!r_valid[r_ptr]) begin
                            r_valid[r_ptr]  <= 1'b1;
                            r_cancel[r_ptr] <= 1'b0;
                            r_load[r_ptr]   <= r_req_ld;
                            r_store[r_ptr]  <= r_req_st;
                            r_known[r_ptr]  <= 1'b0;
                            r_ptr           <= ptr_inc;
                        end
                    end
                    REQ_LOAD: begin
                        if (!ld_err) begin
                            r_cancel[ia] <= 1'b0;
                            r_known[ia]  <= 1'b1;
                        end
                    end
                    REQ_STORE: begin
                        if (!st_err) begin
                            r_known[ia] <= 1'b1;
                        end
                    end
                    REQ_CLEAR: begin
                        if (idx_ok) begin
                            r_valid[ia]  <= 1'b0;
                            r_cancel[ia] <= 1'b0;
                            r_load[ia]   <= 1'b0;
                            r_store[ia]  <= 1'b0;
                            r_known[ia]  <= 1'b0;
                        end
                    end
                    default: ;
                endcase
            end
            if (i_cmd.cmp && hit) begin
                r_cancel[r_walk_k] <= 1'b1;
            end
            if (i_cmd.load_out) begin
                r_out_vld <= 1'b1;
            end else if (i_rsp_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Address memory
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && (((r_req_type == REQ_LOAD) && !ld_err) ||
                           ((r_req_type == REQ_STORE) && !st_err))) begin
            r_mem_addr[ia] <= r_req_addr;
            r_mem_size[ia] <= r_req_size;
        end
        if (i_cmd.rd) begin
            r_rd_addr <= r_mem_addr[r_walk_k];
            r_rd_size <= r_mem_size[r_walk_k];
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_req_type <= i_req_type;
            r_req_idx  <= i_entry_index;
            r_req_ld   <= i_alloc_is_load;
            r_req_st   <= i_alloc_is_store;
            r_req_addr <= i_access_address;
            r_req_size <= i_access_size;
        end
        if (i_cmd.exec) begin
            r_res_ok   <= e_ok;
            r_res_aidx <= e_ok ? IDX_W'(r_ptr) : '0;
            r_res_qv   <= e_qv;
            r_res_qc   <= e_qc;
            r_res_err  <= e_err;
            r_walk_k   <= ia;
        end else if (i_cmd.cmp) begin
            r_walk_k <= n_walk_k;
        end
        if (i_cmd.load_out) begin
            o_alloc_ok        <= r_res_ok;
            o_alloc_index     <= r_res_aidx;
            o_entry_valid     <= r_res_qv;
            o_entry_cancelled <= r_res_qc;
            o_request_error   <= r_res_err;
            o_buffer_empty    <= ~|r_valid;
            o_near_full       <= |(r_valid & win_hit);
        end
    end

    assign o_rsp_valid = r_out_vld;

    a_cancel_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cancel & ~r_valid) == '0)
        else $error("cancel mark on a free entry");

    a_known_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_known & ~r_valid) == '0)
        else $error("address known on a free entry");

    // The store walk stops before it reaches the allocation pointer
    a_walk_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.rd || i_cmd.cmp) |-> (r_walk_k != r_ptr))
        else $error("store walk reached the allocation pointer");

endmodule

`default_nettype wire

/* hdl/memory_ordering_buffer.sv */
// Top level of the memory ordering buffer: controller, datapath, channels.
// Sequence: a request is captured on its transfer and applied in the execute state; then a
//   store scans the entries from the store up to the pointer (read, compare per entry).
// One request at a time: ready only in idle, after the result enters the output register;
//   the walk reads the address memory through its one read port per entry.
// Reset: synchronous active-low; clears all entry flags, pointer, result valid.
`timescale 1ns / 1ps
`default_nettype none

module memory_ordering_buffer
    import mob_pkg::*;
#(
    parameter int BUFFER_DEPTH = 32
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_we,
    input  wire logic [WIN_W-1:0] i_cfg_wdata,
    mob_req_if.sink               i_req,
    mob_rsp_if.source             o_rsp
);

    // Command / status between the sequencer and the datapath
    t_mob_cmd cmd;
    t_mob_sts sts;

    // Sequencer: one request at a time; the request side opens again
    // as soon as the result sits in the output register.
    mob_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (i_req.ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // Datapath: entry flags in flops, addresses in a one-port memory,
    // store walk compares one entry at a time (read, then compare).
    mob_dp #(
        .DEPTH (BUFFER_DEPTH)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_sts             (sts),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_wdata       (i_cfg_wdata),
        .i_req_type        (i_req.req_type),
        .i_entry_index     (i_req.entry_index),
        .i_alloc_is_load   (i_req.alloc_is_load),
        .i_alloc_is_store  (i_req.alloc_is_store),
        .i_access_address  (i_req.access_address),
        .i_access_size     (i_req.access_size),
        .i_rsp_ready       (o_rsp.ready),
        .o_rsp_valid       (o_rsp.valid),
        .o_alloc_ok        (o_rsp.alloc_ok),
        .o_alloc_index     (o_rsp.alloc_index),
        .o_entry_valid     (o_rsp.entry_valid),
        .o_entry_cancelled (o_rsp.entry_cancelled),
        .o_buffer_empty    (o_rsp.buffer_empty),
        .o_near_full       (o_rsp.near_full),
        .o_request_error   (o_rsp.request_error)
    );

endmodule

`default_nettype wire

/* sim/tb_top.sv */
// Self-checking bench for memory_ordering_buffer: directed cases, full ring, random traffic.
`timescale 1ns / 1ps

module tb_top;
    import mob_pkg::*;

    localparam int DEPTH        = 32;
    localparam int LIMIT_CYCLES = 600_000;

    // Request codes the block does not know; both must be flagged.
    localparam logic [TYPE_W-1:0] REQ_UNKNOWN_LO = 3'd5;
    localparam logic [TYPE_W-1:0] REQ_UNKNOWN_HI = 3'd7;
    localparam logic [SIZE_W-1:0] SIZE_BAD_LO    = SIZE_MAX + 3'd1;
    localparam logic [SIZE_W-1:0] SIZE_BAD_HI    = 3'd7;

    typedef struct {
        logic [TYPE_W-1:0] kind;
        logic [IDX_W-1:0]  idx;
        logic              is_load;
        logic              is_store;
        logic [ADDR_W-1:0] addr;
        logic [SIZE_W-1:0] size;
    } t_mob_request;

    typedef struct packed {
        logic             alloc_ok;
        logic [IDX_W-1:0] alloc_index;
        logic             entry_valid;
        logic             entry_cancelled;
        logic             buffer_empty;
        logic             near_full;
        logic             request_error;
    } t_mob_result;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_cfg_we;
    logic [WIN_W-1:0] i_cfg_wdata;

    mob_req_if req_ch ();
    mob_rsp_if rsp_ch ();

    memory_ordering_buffer #(
        .BUFFER_DEPTH (DEPTH)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_req       (req_ch),
        .o_rsp       (rsp_ch)
    );

    // ------------------------------------------------------------------
    // Shadow of the ordering ring, advanced once per accepted request
    // ------------------------------------------------------------------
    logic [DEPTH-1:0]  slot_valid;
    logic [DEPTH-1:0]  slot_cancel;
    logic [DEPTH-1:0]  slot_is_load;
    logic [DEPTH-1:0]  slot_is_store;
    logic [DEPTH-1:0]  slot_addr_known;
    logic [ADDR_W-1:0] slot_addr [DEPTH];
    logic [SIZE_W-1:0] slot_size [DEPTH];
    logic [IDX_W-1:0]  next_slot;
    int unsigned       near_window;

    t_mob_result       pending_results [$];
    logic [ADDR_W-1:0] addr_pool [4];

    int send_gap_pct;
    int rsp_stall_pct;
    int useful_items;
    int n_sent;
    int n_rejected;
    int n_ring_full;
    int n_cancel_seen;
    int fail_count;
    int cycle_count;
    t_mob_result rsp_want;

    // Address bits below the access size take no part in the overlap test
    function automatic logic [ADDR_W-1:0] ignored_bits(input logic [SIZE_W-1:0] sz);
        return (64'd1 << sz) - 64'd1;
    endfunction

    function automatic void free_slot(input logic [IDX_W-1:0] k);
        slot_valid[k]      = 1'b0;
        slot_cancel[k]     = 1'b0;
        slot_is_load[k]    = 1'b0;
        slot_is_store[k]   = 1'b0;
        slot_addr_known[k] = 1'b0;
        slot_addr[k]       = '0;
        slot_size[k]       = '0;
    endfunction

    function automatic t_mob_result apply_request(input t_mob_request r);
        t_mob_result      res;
        logic [IDX_W-1:0] k;
        res = '0;
        case (r.kind)
            REQ_ALLOC: begin
                // pointer entry still busy: ring is full, not an error
                if (!slot_valid[next_slot]) begin
                    free_slot(next_slot);
                    slot_valid[next_slot]    = 1'b1;
                    slot_is_load[next_slot]  = r.is_load;
                    slot_is_store[next_slot] = r.is_store;
                    res.alloc_ok    = 1'b1;
                    res.alloc_index = next_slot;
                    next_slot       = next_slot + 1'b1;
                end
            end
            REQ_LOAD: begin
                if (r.size > SIZE_MAX || !slot_valid[r.idx] || !slot_is_load[r.idx] ||
                    slot_addr_known[r.idx]) begin
                    res.request_error = 1'b1;
                end else begin
                    slot_cancel[r.idx]     = 1'b0;
                    slot_addr_known[r.idx] = 1'b1;
                    slot_addr[r.idx]       = r.addr;
                    slot_size[r.idx]       = r.size;
                end
            end
            REQ_STORE: begin
                if (r.size > SIZE_MAX || !slot_valid[r.idx] || slot_cancel[r.idx] ||
                    !slot_is_store[r.idx] || slot_addr_known[r.idx]) begin
                    res.request_error = 1'b1;
                end else begin
                    slot_addr_known[r.idx] = 1'b1;
                    slot_addr[r.idx]       = r.addr;
                    slot_size[r.idx]       = r.size;
                    // scan younger entries, stop at the allocation pointer
                    k = r.idx;
                    for (int i = 0; i < DEPTH; i++) begin
                        if (k == next_slot) break;
                        if (slot_valid[k] && !slot_cancel[k] && !slot_is_store[k] &&
                            slot_addr_known[k] &&
                            ((slot_addr[k] & ~ignored_bits(slot_size[k])) ==
                             (r.addr & ~ignored_bits(r.size))))
                            slot_cancel[k] = 1'b1;
                        k = k + 1'b1;
                    end
                end
            end
            REQ_CLEAR: free_slot(r.idx);
            REQ_QUERY: begin
                if (slot_valid[r.idx]) begin
                    res.entry_valid     = 1'b1;
                    res.entry_cancelled = slot_cancel[r.idx];
                end
            end
            default: res.request_error = 1'b1;
        endcase
        res.buffer_empty = ~|slot_valid;
        for (int unsigned i = 0; i < near_window; i++)
            if (slot_valid[(next_slot + i) % DEPTH]) res.near_full = 1'b1;
        return res;
    endfunction

    function automatic t_mob_request make_req(input logic [TYPE_W-1:0] kind,
                                              input logic [IDX_W-1:0] idx,
                                              input logic ld, input logic st,
                                              input logic [ADDR_W-1:0] addr,
                                              input logic [SIZE_W-1:0] size);
        t_mob_request r;
        r.kind     = kind;
        r.idx      = idx;
        r.is_load  = ld;
        r.is_store = st;
        r.addr     = addr;
        r.size     = size;
        return r;
    endfunction

    // Mostly addresses near a few shared bases so that stores hit loads
    function automatic logic [ADDR_W-1:0] pick_address();
        if ($urandom_range(4) == 0) return {$urandom, $urandom};
        return {addr_pool[$urandom_range(3)][ADDR_W-1:4], 4'($urandom)};
    endfunction

    // Random entry that can legally take a request of this kind, or -1
    function automatic int pick_slot(input logic [TYPE_W-1:0] kind);
        int cand [$];
        for (int k = 0; k < DEPTH; k++) begin
            case (kind)
                REQ_LOAD:
                    if (slot_valid[k] && slot_is_load[k] && !slot_addr_known[k])
                        cand.push_back(k);
                REQ_STORE:
                    if (slot_valid[k] && slot_is_store[k] && !slot_addr_known[k] &&
                        !slot_cancel[k])
                        cand.push_back(k);
                default:
                    if (slot_valid[k]) cand.push_back(k);
            endcase
        end
        if (cand.size() == 0) return -1;
        return cand[$urandom_range(cand.size() - 1)];
    endfunction

    function automatic void check_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endfunction

    // ------------------------------------------------------------------
    // Clock, reset, receiver and timeout
    // ------------------------------------------------------------------
    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    // Receiver side: ready drops at random per the current stall rate
    always @(posedge i_clk)
        rsp_ch.ready <= ($urandom_range(99) >= rsp_stall_pct);

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_results.size());
            $display("FAILURE");
            $finish;
        end
    end

    // Each response transfer is matched against the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            if (pending_results.size() == 0) begin
                $error("response transfer with no request outstanding");
                fail_count++;
            end else begin
                rsp_want = pending_results.pop_front();
                check_field("alloc_ok",        rsp_want.alloc_ok,        rsp_ch.alloc_ok);
                check_field("alloc_index",     rsp_want.alloc_index,     rsp_ch.alloc_index);
                check_field("entry_valid",     rsp_want.entry_valid,     rsp_ch.entry_valid);
                check_field("entry_cancelled", rsp_want.entry_cancelled,
                            rsp_ch.entry_cancelled);
                check_field("buffer_empty",    rsp_want.buffer_empty,    rsp_ch.buffer_empty);
                check_field("near_full",       rsp_want.near_full,       rsp_ch.near_full);
                check_field("request_error",   rsp_want.request_error,   rsp_ch.request_error);
            end
        end
    end

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------

    // One request transfer. Valid is left high afterwards so back-to-back
    // requests keep it asserted; an optional gap drops it first.
    task automatic send_request(input t_mob_request r);
        t_mob_result want;
        if (send_gap_pct != 0 && $urandom_range(99) < send_gap_pct) begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
        req_ch.valid          <= 1'b1;
        req_ch.req_type       <= r.kind;
        req_ch.entry_index    <= r.idx;
        req_ch.alloc_is_load  <= r.is_load;
        req_ch.alloc_is_store <= r.is_store;
        req_ch.access_address <= r.addr;
        req_ch.access_size    <= r.size;
        do @(posedge i_clk); while (!req_ch.ready);
        want = apply_request(r);
        pending_results.push_back(want);
        n_sent++;
        if (want.request_error) n_rejected++;
        else useful_items++;
        if (r.kind == REQ_ALLOC && !want.alloc_ok && !want.request_error) n_ring_full++;
        if (want.entry_cancelled) n_cancel_seen++;
    endtask

    // Block is idle once every outstanding result has come back
    task automatic drain();
        req_ch.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_window(input logic [WIN_W-1:0] win);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= win;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        near_window = win;
    endtask

    task automatic clear_all();
        for (int k = 0; k < DEPTH; k++)
            if (slot_valid[k]) send_request(make_req(REQ_CLEAR, IDX_W'(k), 0, 0, 0, 0));
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Hand-picked cases from reset, window at its reset value of 8
    task automatic test_directed();
        send_request(make_req(REQ_QUERY, 0, 0, 0, '0, 0));      // empty ring
        send_request(make_req(REQ_ALLOC, 0, 1, 0, '0, 0));      // entry 0 load
        send_request(make_req(REQ_ALLOC, 0, 0, 1, '0, 0));      // entry 1 store
        send_request(make_req(REQ_ALLOC, 0, 1, 0, '0, 0));      // entry 2 load
        send_request(make_req(REQ_ALLOC, 0, 0, 0, '0, 0));      // entry 3 neither
        send_request(make_req(REQ_ALLOC, 0, 1, 1, '0, 0));      // entry 4 both
        send_request(make_req(REQ_LOAD, 0, 0, 0, '1, SIZE_MAX));
        send_request(make_req(REQ_LOAD, 0, 0, 0, '1, SIZE_MAX)); // address already known
        send_request(make_req(REQ_LOAD, 2, 0, 0, '0, SIZE_BAD_LO));
        send_request(make_req(REQ_LOAD, 2, 0, 0, 64'hFFFF_FFFF_FFFF_FFF0, 0));
        send_request(make_req(REQ_LOAD, 1, 0, 0, '0, 0));       // store entry
        send_request(make_req(REQ_LOAD, 3, 0, 0, '0, 0));       // neither kind
        send_request(make_req(REQ_STORE, 0, 0, 0, '0, 0));      // load entry
        // 16-byte store overlaps the younger load at entry 2, not the older one
        send_request(make_req(REQ_STORE, 1, 0, 0, 64'hFFFF_FFFF_FFFF_FFF5, SIZE_MAX));
        send_request(make_req(REQ_QUERY, 2, 0, 0, '0, 0));
        send_request(make_req(REQ_QUERY, 0, 0, 0, '0, 0));
        send_request(make_req(REQ_STORE, 1, 0, 0, '0, 0));      // address already known
        send_request(make_req(REQ_LOAD, 2, 0, 0, '0, 0));       // cancelled, known
        send_request(make_req(REQ_STORE, 3, 0, 0, '0, SIZE_BAD_HI));
        send_request(make_req(REQ_STORE, 4, 0, 0, '0, 0));      // zero address, 1 byte
        send_request(make_req(REQ_CLEAR, 2, 0, 0, '0, 0));
        send_request(make_req(REQ_QUERY, 2, 0, 0, '0, 0));      // free entry, no error
        send_request(make_req(REQ_UNKNOWN_LO, 31, 1, 1, '1, SIZE_BAD_HI));
        send_request(make_req(REQ_UNKNOWN_HI, 0, 0, 0, '0, 0));
        clear_all();
    endtask

    // Fill every entry, try one more, then run stores on the full ring,
    // including the one sitting at the pointer, which scans nothing.
    task automatic test_full_ring();
        logic [IDX_W-1:0] head;
        logic             ld;
        head = next_slot;
        send_request(make_req(REQ_ALLOC, 0, 0, 1, '0, 0));
        for (int i = 1; i < DEPTH; i++) begin
            ld = 1'($urandom_range(1));
            send_request(make_req(REQ_ALLOC, 0, ld, !ld, '0, 0));
        end
        send_request(make_req(REQ_ALLOC, 0, 1, 0, '0, 0));      // ring full
        for (int k = 0; k < DEPTH; k++)
            if (slot_is_load[k])
                send_request(make_req(REQ_LOAD, IDX_W'(k), 0, 0, pick_address(),
                                      SIZE_W'($urandom_range(SIZE_MAX))));
        send_request(make_req(REQ_STORE, head, 0, 0, pick_address(),
                              SIZE_W'($urandom_range(SIZE_MAX))));
        for (int k = 0; k < DEPTH; k++)
            if (slot_is_store[k] && !slot_addr_known[k])
                send_request(make_req(REQ_STORE, IDX_W'(k), 0, 0, pick_address(),
                                      SIZE_W'($urandom_range(SIZE_MAX))));
        for (int k = 0; k < DEPTH; k++)
            send_request(make_req(REQ_QUERY, IDX_W'(k), 0, 0, '0, 0));
        clear_all();
    endtask

    // Mostly legal request streams picked from the current ring contents,
    // with a share of fully random requests mixed in.
    task automatic run_traffic(input int n_items, input int gap_pct, input int stall_pct);
        int                target;
        int                roll;
        int                slot;
        logic [TYPE_W-1:0] kind;
        logic              ld;
        logic              st;
        send_gap_pct  = gap_pct;
        rsp_stall_pct = stall_pct;
        target        = useful_items + n_items;
        while (useful_items < target) begin
            if ($urandom_range(99) < 12) begin
                send_request(make_req(TYPE_W'($urandom_range(7)),
                                      IDX_W'($urandom_range(DEPTH - 1)),
                                      1'($urandom_range(1)), 1'($urandom_range(1)),
                                      {$urandom, $urandom}, SIZE_W'($urandom_range(7))));
            end else begin
                roll = $urandom_range(99);
                if (roll < 28)      kind = REQ_ALLOC;
                else if (roll < 50) kind = REQ_LOAD;
                else if (roll < 66) kind = REQ_STORE;
                else if (roll < 80) kind = REQ_QUERY;
                else                kind = REQ_CLEAR;
                slot = 0;
                if (kind != REQ_ALLOC) begin
                    slot = pick_slot(kind);
                    if (slot < 0) kind = REQ_ALLOC;
                end
                if (kind == REQ_ALLOC) begin
                    roll = $urandom_range(9);
                    ld   = (roll < 5);
                    st   = (roll >= 5);
                    if (roll == 9) begin
                        ld = 1'($urandom_range(1));
                        st = 1'($urandom_range(1));
                    end
                    send_request(make_req(REQ_ALLOC, 0, ld, st, '0, 0));
                end else begin
                    send_request(make_req(kind, IDX_W'(slot), 0, 0, pick_address(),
                                          SIZE_W'($urandom_range(SIZE_MAX))));
                end
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        i_rst_n               = 1'b0;
        i_cfg_we              = 1'b0;
        i_cfg_wdata           = '0;
        req_ch.valid          = 1'b0;
        req_ch.req_type       = REQ_QUERY;
        req_ch.entry_index    = '0;
        req_ch.alloc_is_load  = 1'b0;
        req_ch.alloc_is_store = 1'b0;
        req_ch.access_address = '0;
        req_ch.access_size    = '0;
        rsp_ch.ready          = 1'b0;
        send_gap_pct          = 0;
        rsp_stall_pct         = 0;
        useful_items          = 0;
        n_sent                = 0;
        n_rejected            = 0;
        n_ring_full           = 0;
        n_cancel_seen         = 0;
        fail_count            = 0;
        cycle_count           = 0;
        for (int k = 0; k < DEPTH; k++) free_slot(IDX_W'(k));
        next_slot   = '0;
        near_window = WINDOW_RST;
        for (int i = 0; i < 4; i++) addr_pool[i] = {$urandom, $urandom};

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_full_ring();
        set_window(6'd1);
        run_traffic(170, 0, 0);
        set_window(6'd32);
        run_traffic(170, 50, 0);
        set_window(6'd17);
        run_traffic(160, 0, 50);
        set_window(WIN_W'($urandom_range(2, 31)));
        run_traffic(160, 15, 15);

        drain();
        repeat (10) @(posedge i_clk);
        $display("%0d request transfers: %0d flagged, %0d allocs on a full ring,",
                 n_sent, n_rejected, n_ring_full);
        $display("%0d cancelled entries seen by query; windows 8, 1, 32, 17 and random",
                 n_cancel_seen);
        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("%0d mismatches", fail_count);
            $display("FAILURE");
        end
        $finish;
    end

endmodule
